// ----- rtl/pqpc_pkg.sv -----
package pqpc_pkg;

    localparam int DVD_W = 25;
    localparam int DVS_W = 17;
    localparam int QUO_W = 7;
    localparam int CNT_W = 3;

    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_CALIB     = 3'd1;
    localparam logic [2:0] REG_SAFETY    = 3'd2;
    localparam logic [2:0] REG_RATE      = 3'd3;
    localparam logic [2:0] REG_MIN_POWER = 3'd4;
    localparam logic [2:0] REG_CORRIDOR  = 3'd5;

    localparam logic [15:0]        P_RANGE_MAX = 16'd19200;
    localparam logic signed [13:0] V_MIN       = -14'sd100;
    localparam logic signed [13:0] V_MAX       = 14'sd5100;
    localparam logic [15:0]        SAFE_LO     = 16'd1280;
    localparam logic [15:0]        SAFE_HI     = 16'd51200;
    localparam logic [9:0]         RATE_LO     = 10'd1;
    localparam logic [9:0]         RATE_HI     = 10'd200;
    localparam logic [6:0]         PWR_FULL    = 7'd100;
    localparam logic [23:0]        DT_MIN      = 24'd960;
    localparam logic [16:0]        JUMP_FREE   = 17'd256;
    localparam logic [26:0]        STEP_SCALE  = 27'd625;
    localparam logic [24:0]        CAP_SCALE   = 25'd201;

    typedef struct packed {
        logic [6:0]  applied_power;
        logic        limited;
        logic        emergency_stop;
        logic        fallback_active;
        logic        signal_valid;
        logic        signal_stable;
        logic [15:0] corridor_used;
    } result_t;

endpackage

// ----- rtl/pqpc_div.sv -----
module pqpc_div import pqpc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int DSR_W = DVS_W + QUO_W - 1;

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DVD_W:0]   trial;
    logic             take;

    assign trial = {1'b0, rem_reg} - {{(DVD_W + 1 - DSR_W){1'b0}}, dsr_reg};
    assign take  = ~trial[DVD_W];

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(QUO_W - 1);
            rem_next = dividend;
            dsr_next = {divisor, {(QUO_W - 1){1'b0}}};
            quo_next = '0;
        end else if (run_reg) begin
            quo_next = {quo_reg[QUO_W-2:0], take};
            rem_next = take ? trial[DVD_W-1:0] : rem_reg;
            dsr_next = dsr_reg >> 1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/pressure_qualified_power_cap.sv -----
// Channel   Direction  Handshake           Payload
// s_        input      s_valid / s_ready   power request, times, sensor status, pressure, voltage
// m_        output     m_valid / m_ready   applied power, flags, corridor used
// cfg_      input      cfg_we              cfg_index selects one of six registers
//
// A transaction goes from acceptance to a loaded result through ST_QUAL and ST_OUT when disabled
// or when the sample is rejected, adds ST_MUL and ST_STAB when no cap is computed, and adds ST_PREP
// and ST_DIV, with the 7-step restoring divider, when the linear cap runs.
// The input is ready only while the sequencer is idle; one result register holds the
// answer, so the next transaction is taken while that result waits for m_ready.
// Reset is synchronous; configuration registers return to their defaults.
module pressure_qualified_power_cap import pqpc_pkg::*; #(
    parameter int SENSOR_TIMEOUT_MS = 5000,
    parameter int STABLE_RUN        = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_requested_power,
    input  logic [31:0]        s_now_ms,
    input  logic [31:0]        s_sample_ms,
    input  logic               s_sensor_ok,
    input  logic signed [16:0] s_pressure,
    input  logic signed [13:0] s_sensor_voltage,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [6:0]         m_applied_power,
    output logic               m_limited,
    output logic               m_emergency_stop,
    output logic               m_fallback_active,
    output logic               m_signal_valid,
    output logic               m_signal_stable,
    output logic [15:0]        m_corridor_used
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_QUAL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_STAB = 3'd3;
    localparam logic [2:0] ST_PREP = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [1:0]  RUN     = STABLE_RUN[1:0];
    localparam logic [31:0] TIMEOUT = SENSOR_TIMEOUT_MS[31:0];

    logic        enable_reg;
    logic        calib_reg;
    logic [15:0] safety_reg;
    logic [9:0]  rate_cfg_reg;
    logic [7:0]  minpwr_reg;
    logic [15:0] corridor_reg;

    logic [2:0]  state_reg, state_next;
    logic        primed_reg, primed_next;
    logic [1:0]  count_reg, count_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [16:0] last_p_reg, last_p_next;

    logic [6:0]  req_reg, req_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] smp_reg, smp_next;
    logic        ok_reg, ok_next;
    logic [16:0] p_reg, p_next;
    logic [13:0] v_reg, v_next;

    logic [16:0] ad_reg, ad_next;
    logic [23:0] dm_reg, dm_next;
    logic        dbig_reg, dbig_next;
    logic        lt_reg, lt_next;
    logic        gt_reg, gt_next;
    logic [15:0] s_reg, s_next;
    logic [15:0] c_reg, c_next;
    logic [6:0]  m_reg, m_next;
    logic [7:0]  rate_reg, rate_next;
    logic [26:0] prod_a_reg, prod_a_next;
    logic [31:0] prod_b_reg, prod_b_next;
    logic [22:0] num_reg, num_next;
    logic [15:0] den_reg, den_next;

    result_t     res_reg, res_next;
    result_t     out_reg, out_next;
    logic        m_valid_reg, m_valid_next;

    logic        div_start;
    logic        div_done;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [QUO_W-1:0] div_quotient;

    logic [31:0] age;
    logic        sig_ok;
    logic [31:0] dt;
    logic [17:0] pdiff;
    logic [17:0] pabs;
    logic [15:0] s_clamp;
    logic [15:0] c_raw;
    logic [17:0] s_three;
    logic        c_high;
    logic        step_ok;
    logic [1:0]  count_new;
    logic        stable_now;
    logic [15:0] pc;
    logic [6:0]  cap;
    logic [6:0]  ap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            calib_reg    <= 1'b0;
            safety_reg   <= 16'd25600;
            rate_cfg_reg <= 10'd10;
            minpwr_reg   <= 8'd30;
            corridor_reg <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE:    enable_reg   <= cfg_wdata[0];
                REG_CALIB:     calib_reg    <= cfg_wdata[0];
                REG_SAFETY:    safety_reg   <= cfg_wdata;
                REG_RATE:      rate_cfg_reg <= cfg_wdata[9:0];
                REG_MIN_POWER: minpwr_reg   <= cfg_wdata[7:0];
                REG_CORRIDOR:  corridor_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign age    = now_reg - smp_reg;
    assign sig_ok = calib_reg && ok_reg && (smp_reg != 32'd0) && (now_reg >= smp_reg) &&
                    (age <= TIMEOUT) && !p_reg[16] && (p_reg[15:0] <= P_RANGE_MAX) &&
                    ($signed(v_reg) >= V_MIN) && ($signed(v_reg) <= V_MAX);
    assign dt     = smp_reg - last_time_reg;
    assign pdiff  = {p_reg[16], p_reg} - {last_p_reg[16], last_p_reg};
    assign pabs   = pdiff[17] ? (18'd0 - pdiff) : pdiff;

    assign s_clamp = (safety_reg < SAFE_LO) ? SAFE_LO :
                     (safety_reg > SAFE_HI) ? SAFE_HI : safety_reg;
    assign c_raw   = (corridor_reg == 16'd0) ? (s_clamp >> 1) : corridor_reg;
    assign s_three = {2'b00, s_clamp} + {1'b0, s_clamp, 1'b0};
    assign c_high  = ({4'd0, c_raw} * 20'd10) >= ({4'd0, s_clamp} * 20'd9);

    assign step_ok = (ad_reg <= JUMP_FREE) || dbig_reg ||
                     ({7'd0, prod_a_reg} <= {prod_b_reg, 2'b00});

    always_comb begin
        if (!primed_reg || lt_reg) begin
            count_new = 2'd1;
        end else if (gt_reg) begin
            if (step_ok) begin
                count_new = (count_reg < RUN) ? count_reg + 2'd1 : count_reg;
            end else begin
                count_new = 2'd1;
            end
        end else begin
            count_new = count_reg;
        end
    end

    assign stable_now = (count_new >= RUN);
    assign pc         = p_reg[15:0] - c_reg;
    assign cap        = (div_quotient > PWR_FULL) ? PWR_FULL : div_quotient;
    assign ap         = (req_reg < cap) ? req_reg : cap;

    assign div_dividend = 25'(den_reg) * CAP_SCALE - {1'b0, num_reg, 1'b0};
    assign div_divisor  = {den_reg, 1'b0};
    assign div_start    = (state_reg == ST_PREP);

    pqpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next     = state_reg;
        primed_next    = primed_reg;
        count_next     = count_reg;
        last_time_next = last_time_reg;
        last_p_next    = last_p_reg;
        req_next       = req_reg;
        now_next       = now_reg;
        smp_next       = smp_reg;
        ok_next        = ok_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        ad_next        = ad_reg;
        dm_next        = dm_reg;
        dbig_next      = dbig_reg;
        lt_next        = lt_reg;
        gt_next        = gt_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        m_next         = m_reg;
        rate_next      = rate_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = (s_requested_power > 8'd100) ? PWR_FULL
                                                               : s_requested_power[6:0];
                    now_next   = s_now_ms;
                    smp_next   = s_sample_ms;
                    ok_next    = s_sensor_ok;
                    p_next     = s_pressure;
                    v_next     = s_sensor_voltage;
                    state_next = ST_QUAL;
                end
            end
            ST_QUAL: begin
                res_next = '0;
                res_next.applied_power = req_reg;
                if (!enable_reg) begin
                    primed_next    = 1'b0;
                    count_next     = 2'd0;
                    last_time_next = 32'd0;
                    last_p_next    = 17'd0;
                    state_next     = ST_OUT;
                end else if (!sig_ok) begin
                    primed_next    = 1'b0;
                    count_next     = 2'd0;
                    last_time_next = 32'd0;
                    res_next.fallback_active = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    ad_next   = pabs[16:0];
                    dbig_next = (dt[31:24] != 8'd0);
                    dm_next   = (dt[23:0] < DT_MIN) ? DT_MIN : dt[23:0];
                    lt_next   = smp_reg < last_time_reg;
                    gt_next   = smp_reg > last_time_reg;
                    s_next    = s_clamp;
                    c_next    = c_high ? s_three[17:2] : c_raw;
                    m_next    = (minpwr_reg > 8'd100) ? PWR_FULL : minpwr_reg[6:0];
                    rate_next = (rate_cfg_reg < RATE_LO) ? 8'd1 :
                                (rate_cfg_reg > RATE_HI) ? 8'd200 : rate_cfg_reg[7:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_a_next = 27'(ad_reg) * STEP_SCALE;
                prod_b_next = 32'(rate_reg) * 32'(dm_reg);
                state_next  = ST_STAB;
            end
            ST_STAB: begin
                primed_next    = 1'b1;
                count_next     = count_new;
                last_time_next = smp_reg;
                last_p_next    = p_reg;
                res_next.signal_valid = 1'b1;
                if (!stable_now) begin
                    res_next.fallback_active = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    res_next.signal_stable = 1'b1;
                    res_next.corridor_used = c_reg;
                    if (p_reg[15:0] >= s_reg) begin
                        res_next.applied_power  = 7'd0;
                        res_next.emergency_stop = 1'b1;
                        state_next = ST_OUT;
                    end else if (p_reg[15:0] <= c_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        num_next   = 23'(pc) * 23'(PWR_FULL - m_reg);
                        den_next   = s_reg - c_reg;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next.applied_power = ap;
                    res_next.limited       = (ap < req_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            count_reg     <= 2'd0;
            last_time_reg <= 32'd0;
            last_p_reg    <= 17'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            count_reg     <= count_next;
            last_time_reg <= last_time_next;
            last_p_reg    <= last_p_next;
            m_valid_reg   <= m_valid_next;
        end
        req_reg    <= req_next;
        now_reg    <= now_next;
        smp_reg    <= smp_next;
        ok_reg     <= ok_next;
        p_reg      <= p_next;
        v_reg      <= v_next;
        ad_reg     <= ad_next;
        dm_reg     <= dm_next;
        dbig_reg   <= dbig_next;
        lt_reg     <= lt_next;
        gt_reg     <= gt_next;
        s_reg      <= s_next;
        c_reg      <= c_next;
        m_reg      <= m_next;
        rate_reg   <= rate_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_applied_power   = out_reg.applied_power;
    assign m_limited         = out_reg.limited;
    assign m_emergency_stop  = out_reg.emergency_stop;
    assign m_fallback_active = out_reg.fallback_active;
    assign m_signal_valid    = out_reg.signal_valid;
    assign m_signal_stable   = out_reg.signal_stable;
    assign m_corridor_used   = out_reg.corridor_used;

endmodule
